// ===== sv/zfpid_pkg.sv =====
package zfpid_pkg;

    typedef enum logic [1:0] {
        MODE_INTEG  = 2'd0,
        MODE_PI     = 2'd1,
        MODE_PID    = 2'd2,
        MODE_PID_AW = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_SET_POINT = 3'd4,
        REG_INT_LIMIT = 3'd5
    } reg_idx_t;

    localparam logic signed [26:0] FULL_SCALE  = 27'sd65535;
    localparam logic [16:0]        SMALL_ERROR = 17'd100;
    // floor(x / 125) = (x * RECIP_125) >> RECIP_SHIFT, exact for x < 2**31
    localparam logic [31:0]        RECIP_125   = 32'd2199023256;
    localparam int                 RECIP_SHIFT = 38;

    typedef struct packed {
        mode_t              mode;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic signed [15:0] set_point;
        logic [15:0]        int_limit;
    } cfg_t;

    // operands for the multiplier stage
    typedef struct packed {
        logic signed [17:0] x1;
        logic signed [15:0] g1;
        logic signed [17:0] x2;
        logic signed [15:0] g2;
        logic signed [16:0] xi;
        logic signed [15:0] gi;
        logic               positional;
        logic               integ_en;
        logic signed [16:0] deviation;
    } op_t;

    typedef struct packed {
        logic signed [34:0] n_drive;
        logic signed [34:0] n_int;
        logic               positional;
        logic               integ_en;
        logic signed [16:0] deviation;
    } num_t;

    typedef struct packed {
        logic [30:0] mag;
        logic        inv;
        logic        neg;
    } div_prep_t;

    typedef struct packed {
        logic [24:0]        q_drive;
        logic               inv_drive;
        logic               neg_drive;
        logic [24:0]        q_int;
        logic               inv_int;
        logic               neg_int;
        logic               positional;
        logic               integ_en;
        logic signed [16:0] deviation;
    } quo_t;

    // split n/1000 into a shift by 3 and a magnitude for the /125 multiply
    function automatic div_prep_t div_prep(input logic signed [34:0] n,
                                           input logic trunc_mode);
        logic signed [34:0] x;
        logic signed [31:0] y;
        div_prep_t          r;
        r.neg = trunc_mode && n[34];
        x     = r.neg ? -n : n;
        y     = x[34:3];
        r.inv = y[31];
        r.mag = y[31] ? ~y[30:0] : y[30:0];
        return r;
    endfunction

    // floor of a negative value is the complement of floor of its complement
    function automatic logic signed [25:0] div_done(input logic [24:0] q,
                                                    input logic inv,
                                                    input logic neg);
        logic signed [25:0] r;
        r = {1'b0, q};
        if (inv) r = ~r;
        if (neg) r = -r;
        return r;
    endfunction

    function automatic logic [15:0] clamp_full(input logic signed [26:0] v);
        logic [15:0] r;
        if (v < 0) r = '0;
        else if (v > FULL_SCALE) r = 16'hFFFF;
        else r = v[15:0];
        return r;
    endfunction

endpackage

// ===== sv/z_feedback_pid_controller.sv =====
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata: sample; s_tuser: first_of_burst
// m_       out  m_tvalid/m_tready  m_tdata: dac_value, deviation
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one sample per cycle sustained while m_tready is high; five register stages from input to result
// (input, operand select, gain multiply, divide by 1000, loop state update)
// the loop state (drive level, integral) closes in the last stage only
// aresetn clears all valid flags, the loop state, the previous error and
// the configuration; cfg_ready is always high
// a stalled result holds its stage; earlier stages keep filling bubbles
module z_feedback_pid_controller
    import zfpid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tuser,   // [0] first_of_burst
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] dac_value, [32:16] deviation, [39:33] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg;
    logic op_valid;
    logic op_ready;
    op_t  op;
    logic quo_valid;
    logic quo_ready;
    quo_t quo;

    zfpid_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    zfpid_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    zfpid_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .quo_valid (quo_valid),
        .quo_ready (quo_ready),
        .quo       (quo)
    );

    zfpid_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .quo_valid (quo_valid),
        .quo_ready (quo_ready),
        .quo       (quo),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== sv/zfpid_cfg.sv =====
module zfpid_cfg
    import zfpid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode      <= MODE_INTEG;
            cfg_reg.gain_p    <= '0;
            cfg_reg.gain_i    <= '0;
            cfg_reg.gain_d    <= '0;
            cfg_reg.set_point <= '0;
            cfg_reg.int_limit <= '0;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:      cfg_reg.mode      <= mode_t'(cfg_data[1:0]);
                REG_GAIN_P:    cfg_reg.gain_p    <= cfg_data;
                REG_GAIN_I:    cfg_reg.gain_i    <= cfg_data;
                REG_GAIN_D:    cfg_reg.gain_d    <= cfg_data;
                REG_SET_POINT: cfg_reg.set_point <= cfg_data;
                REG_INT_LIMIT: cfg_reg.int_limit <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/zfpid_front.sv =====
module zfpid_front
    import zfpid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    output logic        op_valid,
    input  logic        op_ready,
    output op_t         op
);

    logic               smp_valid_reg;
    logic signed [15:0] sample_reg;
    logic               first_reg;
    logic               op_valid_reg;
    op_t                op_reg;
    op_t                op_next;
    logic signed [16:0] prev_err_reg;

    logic               smp_ready;
    logic               op_free;
    logic               op_load;
    logic signed [16:0] err;
    logic signed [16:0] err_bias;
    logic signed [16:0] e_quart;
    logic signed [16:0] e0;
    logic signed [16:0] p_sel;
    logic [16:0]        err_abs;

    assign op_free   = !op_valid_reg || op_ready;
    assign smp_ready = !smp_valid_reg || op_free;
    assign op_load   = smp_valid_reg && op_free;
    assign s_tready  = smp_ready;
    assign op_valid  = op_valid_reg;
    assign op        = op_reg;

    assign err      = {cfg.set_point[15], cfg.set_point} - {sample_reg[15], sample_reg};
    assign err_abs  = err[16] ? 17'(-err) : 17'(err);
    // divide by 4 toward zero
    assign err_bias = err[16] ? err + 17'sd3 : err;
    assign e_quart  = err_bias >>> 2;
    assign e0       = (err_abs < SMALL_ERROR) ? e_quart : err;
    assign p_sel    = first_reg ? err : prev_err_reg;

    always_comb begin
        op_next            = '0;
        op_next.xi         = err;
        op_next.gi         = cfg.gain_i;
        op_next.deviation  = -err;
        op_next.integ_en   = (cfg.mode == MODE_PID) || (err_abs < {1'b0, cfg.int_limit});
        unique case (cfg.mode)
            MODE_INTEG: begin
                op_next.x1 = {e0[16], e0};
                op_next.g1 = cfg.gain_i;
                op_next.x2 = '0;
                op_next.g2 = cfg.gain_p;
            end
            MODE_PI: begin
                op_next.x1 = {err[16], err} + {p_sel[16], p_sel};
                op_next.g1 = cfg.gain_i;
                op_next.x2 = {err[16], err} - {p_sel[16], p_sel};
                op_next.g2 = cfg.gain_p;
            end
            MODE_PID, MODE_PID_AW: begin
                op_next.positional = 1'b1;
                op_next.x1 = {err[16], err};
                op_next.g1 = cfg.gain_p;
                op_next.x2 = first_reg ? 18'sd0
                                       : {err[16], err} - {prev_err_reg[16], prev_err_reg};
                op_next.g2 = cfg.gain_d;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smp_valid_reg <= 1'b0;
            op_valid_reg  <= 1'b0;
            prev_err_reg  <= '0;
        end else begin
            if (smp_ready) smp_valid_reg <= s_tvalid;
            if (op_free) op_valid_reg <= smp_valid_reg;
            if (op_load) prev_err_reg <= err;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && smp_ready) begin
            sample_reg <= s_tdata;
            first_reg  <= s_tuser;
        end
        if (op_load) op_reg <= op_next;
    end

endmodule

// ===== sv/zfpid_mult.sv =====
module zfpid_mult
    import zfpid_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic op_valid,
    output logic op_ready,
    input  op_t  op,
    output logic quo_valid,
    input  logic quo_ready,
    output quo_t quo
);

    logic  num_valid_reg;
    num_t  num_reg;
    num_t  num_next;
    logic  quo_valid_reg;
    quo_t  quo_reg;
    quo_t  quo_next;

    logic  num_free;
    logic  quo_free;
    logic  num_load;
    logic  quo_load;

    logic signed [33:0] p1;
    logic signed [33:0] p2;
    logic signed [32:0] p3;
    div_prep_t          prep_drive;
    div_prep_t          prep_int;
    logic [62:0]        prod_drive;
    logic [62:0]        prod_int;

    assign quo_free  = !quo_valid_reg || quo_ready;
    assign num_free  = !num_valid_reg || quo_free;
    assign num_load  = op_valid && num_free;
    assign quo_load  = num_valid_reg && quo_free;
    assign op_ready  = num_free;
    assign quo_valid = quo_valid_reg;
    assign quo       = quo_reg;

    // gain products
    assign p1 = op.x1 * op.g1;
    assign p2 = op.x2 * op.g2;
    assign p3 = op.xi * op.gi;

    always_comb begin
        num_next            = '0;
        num_next.n_drive    = {p1[33], p1} + {p2[33], p2};
        num_next.n_int      = {{2{p3[32]}}, p3};
        num_next.positional = op.positional;
        num_next.integ_en   = op.integ_en;
        num_next.deviation  = op.deviation;
    end

    // division by 1000 as a shift and a reciprocal multiply
    assign prep_drive = div_prep(num_reg.n_drive, !num_reg.positional);
    assign prep_int   = div_prep(num_reg.n_int, 1'b0);
    assign prod_drive = prep_drive.mag * RECIP_125;
    assign prod_int   = prep_int.mag * RECIP_125;

    always_comb begin
        quo_next            = '0;
        quo_next.q_drive    = prod_drive[62:RECIP_SHIFT];
        quo_next.inv_drive  = prep_drive.inv;
        quo_next.neg_drive  = prep_drive.neg;
        quo_next.q_int      = prod_int[62:RECIP_SHIFT];
        quo_next.inv_int    = prep_int.inv;
        quo_next.neg_int    = prep_int.neg;
        quo_next.positional = num_reg.positional;
        quo_next.integ_en   = num_reg.integ_en;
        quo_next.deviation  = num_reg.deviation;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_valid_reg <= 1'b0;
            quo_valid_reg <= 1'b0;
        end else begin
            if (num_free) num_valid_reg <= op_valid;
            if (quo_free) quo_valid_reg <= num_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (num_load) num_reg <= num_next;
        if (quo_load) quo_reg <= quo_next;
    end

    // a stalled stage keeps its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (num_valid_reg && !quo_free) |=> (num_valid_reg && $stable(num_reg)))
        else $error("multiplier stage lost a stalled item");

endmodule

// ===== sv/zfpid_accum.sv =====
module zfpid_accum
    import zfpid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        quo_valid,
    output logic        quo_ready,
    input  quo_t        quo,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata
);

    logic               out_valid_reg;
    logic [15:0]        drive_level_reg;
    logic [15:0]        drive_level_next;
    logic [15:0]        integral_reg;
    logic [15:0]        integral_next;
    logic signed [16:0] deviation_reg;

    logic               out_free;
    logic               load;
    logic signed [25:0] step;
    logic signed [25:0] istep;
    logic signed [26:0] integ_sum;
    logic signed [26:0] drive_sum;
    logic [15:0]        drive_base;

    assign out_free  = !out_valid_reg || m_tready;
    assign load      = quo_valid && out_free;
    assign quo_ready = out_free;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'b0, deviation_reg, drive_level_reg};

    assign step  = div_done(quo.q_drive, quo.inv_drive, quo.neg_drive);
    assign istep = div_done(quo.q_int, quo.inv_int, quo.neg_int);

    always_comb begin
        integ_sum     = {11'b0, integral_reg} + {istep[25], istep};
        integral_next = (quo.positional && quo.integ_en) ? clamp_full(integ_sum)
                                                         : integral_reg;
        // positional modes rebuild the drive from the integral
        drive_base       = quo.positional ? integral_next : drive_level_reg;
        drive_sum        = {11'b0, drive_base} + {step[25], step};
        drive_level_next = clamp_full(drive_sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            drive_level_reg <= '0;
            integral_reg    <= '0;
        end else begin
            if (out_free) out_valid_reg <= quo_valid;
            if (load) begin
                drive_level_reg <= drive_level_next;
                integral_reg    <= integral_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) deviation_reg <= quo.deviation;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> ($stable(drive_level_reg) && $stable(integral_reg)))
        else $error("loop state changed without a transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !(quo.positional && quo.integ_en)) |=> $stable(integral_reg))
        else $error("integral changed while integration was off");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && quo.positional && !quo.integ_en && $past(load))
            |=> (drive_level_reg == clamp_full({11'b0, integral_reg}
                                   + {$past(step[25]), $past(step)})))
        else $error("positional drive not built from the held integral");

endmodule
